// ===== rtl/hmrs_pkg.sv =====
// hmrs_pkg: sizes, move and candidate codes, and the command and status
// structs shared by the height map shadow test controller and datapath.
// No dependencies.
package hmrs_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 256;
    localparam int HEIGHT_BITS = 16;

    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int RC_IN_W     = 8;
    localparam int HEIGHT_IN_W = 16;
    localparam int DIR_W       = 11;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int IDX_A_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int IDX_B_W = (IDX_A_W > RC_IN_W) ? IDX_A_W : RC_IN_W;
    localparam int IDX_C_W = (IDX_B_W > CFG_W) ? IDX_B_W : CFG_W;
    localparam int POS_W   = IDX_C_W + 2;

    localparam int MAX_RC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int LR_W   = $clog2(2 * MAX_RC + 8);
    localparam int D_W    = LR_W + DIR_W + 2;
    localparam int PROD_W = HEIGHT_BITS + DIR_W + 3;
    localparam int CMP_W  = (PROD_W > D_W) ? PROD_W : D_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS,
        CFG_COLS
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MOVE_ROW,
        MOVE_COL,
        MOVE_CORNER
    } t_move;

    typedef enum logic [1:0] {
        CAND_CUR,
        CAND_ROW,
        CAND_COL,
        CAND_DIAG
    } t_cand;

    typedef struct packed {
        logic  load_write;
        logic  start;
        logic  latch_hs;
        logic  rd_en;
        t_cand rd_sel;
        logic  advance;
    } t_dp_cmd;

    typedef struct packed {
        logic  zero_dir;
        logic  pos_ok;
        logic  row_ok;
        logic  col_ok;
        logic  diag_ok;
        t_move move;
        logic  blocked;
    } t_dp_sts;

endpackage

// ===== rtl/hmrs_dp.sv =====
// hmrs_dp: datapath of the shadow test; height memory, config registers,
// ray position, crossing bookkeeping and the exact blocking compare.
// Depends on hmrs_pkg.
module hmrs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [hmrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hmrs_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [hmrs_pkg::RC_IN_W-1:0]        i_row,
    input  logic [hmrs_pkg::RC_IN_W-1:0]        i_col,
    input  logic [hmrs_pkg::HEIGHT_IN_W-1:0]    i_height,
    input  logic signed [hmrs_pkg::DIR_W-1:0]   i_dir_row,
    input  logic signed [hmrs_pkg::DIR_W-1:0]   i_dir_col,
    input  logic signed [hmrs_pkg::DIR_W-1:0]   i_dir_z,
    input  hmrs_pkg::t_dp_cmd                   i_cmd,
    output hmrs_pkg::t_dp_sts                   o_sts
);
    import hmrs_pkg::*;

    logic [HEIGHT_BITS-1:0] r_mem [MEM_DEPTH];
    logic [HEIGHT_BITS-1:0] r_rd_data;
    logic [HEIGHT_BITS-1:0] r_hs;

    logic [CFG_W-1:0]              r_rows;
    logic [CFG_W-1:0]              r_cols;
    logic signed [POS_W-1:0]       r_pos_r;
    logic signed [POS_W-1:0]       r_pos_c;
    logic                          r_neg_r;
    logic                          r_neg_c;
    logic [DIR_W-1:0]              r_ar;
    logic [DIR_W-1:0]              r_ac;
    logic signed [DIR_W-1:0]       r_dz;
    logic signed [D_W-1:0]         r_d;
    logic signed [D_W-1:0]         r_pr;
    logic signed [D_W-1:0]         r_pc;

    logic [DIR_W-1:0]              in_ar;
    logic [DIR_W-1:0]              in_ac;
    logic [POS_W-1:0]              nr;
    logic [POS_W-1:0]              nc;
    logic [POS_W-1:0]              rows_x;
    logic [POS_W-1:0]              cols_x;
    logic signed [POS_W-1:0]       step_r;
    logic signed [POS_W-1:0]       step_c;
    logic signed [POS_W-1:0]       sel_r;
    logic signed [POS_W-1:0]       sel_c;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ADDR_W-1:0]             wr_addr;
    logic                          ld_ok;
    t_move                         move;
    logic signed [D_W-1:0]         dz2;
    logic signed [D_W-1:0]         ar2;
    logic signed [D_W-1:0]         ac2;
    logic signed [HEIGHT_BITS:0]   diff;
    logic [DIR_W:0]                den;
    logic signed [D_W-1:0]         num;
    logic signed [PROD_W-1:0]      prod;

    function automatic logic in_range(input logic signed [POS_W-1:0] p,
                                      input logic [POS_W-1:0] n);
        return !p[POS_W-1] && ($unsigned(p) < n);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    assign in_ar = i_dir_row[DIR_W-1] ? DIR_W'(-i_dir_row) : DIR_W'(i_dir_row);
    assign in_ac = i_dir_col[DIR_W-1] ? DIR_W'(-i_dir_col) : DIR_W'(i_dir_col);

    // grid in use, saturated to the map size
    assign rows_x = POS_W'(r_rows);
    assign cols_x = POS_W'(r_cols);
    assign nr     = (rows_x > POS_W'(MAX_ROWS)) ? POS_W'(MAX_ROWS) : rows_x;
    assign nc     = (cols_x > POS_W'(MAX_COLS)) ? POS_W'(MAX_COLS) : cols_x;

    assign step_r = r_neg_r ? r_pos_r - POS_W'(1) : r_pos_r + POS_W'(1);
    assign step_c = r_neg_c ? r_pos_c - POS_W'(1) : r_pos_c + POS_W'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            CAND_CUR: begin
                sel_r = r_pos_r;
                sel_c = r_pos_c;
            end
            CAND_ROW: begin
                sel_r = step_r;
                sel_c = r_pos_c;
            end
            CAND_COL: begin
                sel_r = r_pos_r;
                sel_c = step_c;
            end
            CAND_DIAG: begin
                sel_r = step_r;
                sel_c = step_c;
            end
            default: begin
                sel_r = r_pos_r;
                sel_c = r_pos_c;
            end
        endcase
    end

    assign rd_addr = cell_addr(sel_r[ROW_W-1:0], sel_c[COL_W-1:0]);
    assign wr_addr = cell_addr(ROW_W'(i_row), COL_W'(i_col));
    assign ld_ok   = (POS_W'(i_row) < POS_W'(MAX_ROWS)) &&
                     (POS_W'(i_col) < POS_W'(MAX_COLS));

    // which boundary the ray crosses next
    always_comb begin
        if (r_ac == '0) begin
            move = MOVE_ROW;
        end else if (r_ar == '0) begin
            move = MOVE_COL;
        end else if (r_d < 0) begin
            move = MOVE_ROW;
        end else if (r_d > 0) begin
            move = MOVE_COL;
        end else begin
            move = MOVE_CORNER;
        end
    end

    assign dz2 = D_W'(r_dz) + D_W'(r_dz);
    assign ar2 = $signed(D_W'({r_ar, 1'b0}));
    assign ac2 = $signed(D_W'({r_ac, 1'b0}));

    // (hc - hs) * den >= num * dz, num * dz kept incrementally
    assign diff = $signed({1'b0, r_rd_data}) - $signed({1'b0, r_hs});
    assign den  = (move == MOVE_COL) ? {r_ac, 1'b0} : {r_ar, 1'b0};
    assign num  = (move == MOVE_COL) ? r_pc : r_pr;
    assign prod = PROD_W'(diff) * $signed(PROD_W'(den));

    assign o_sts.zero_dir = (r_ar == '0) && (r_ac == '0);
    assign o_sts.pos_ok   = in_range(r_pos_r, nr) && in_range(r_pos_c, nc);
    assign o_sts.row_ok   = in_range(step_r, nr) && in_range(r_pos_c, nc);
    assign o_sts.col_ok   = in_range(r_pos_r, nr) && in_range(step_c, nc);
    assign o_sts.diag_ok  = in_range(step_r, nr) && in_range(step_c, nc);
    assign o_sts.move     = move;
    assign o_sts.blocked  = CMP_W'(prod) >= CMP_W'(num);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write && ld_ok) begin
            r_mem[wr_addr] <= HEIGHT_BITS'(i_height);
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(256);
            r_cols <= CFG_W'(256);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  r_rows <= r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos_r <= $signed(POS_W'(i_row));
            r_pos_c <= $signed(POS_W'(i_col));
            r_neg_r <= i_dir_row[DIR_W-1];
            r_neg_c <= i_dir_col[DIR_W-1];
            r_ar    <= in_ar;
            r_ac    <= in_ac;
            r_dz    <= i_dir_z;
            r_d     <= $signed(D_W'(in_ac)) - $signed(D_W'(in_ar));
            r_pr    <= D_W'(i_dir_z);
            r_pc    <= D_W'(i_dir_z);
        end else if (i_cmd.advance) begin
            case (move)
                MOVE_ROW: begin
                    r_pos_r <= step_r;
                    r_d     <= r_d + ac2;
                    r_pr    <= r_pr + dz2;
                end
                MOVE_COL: begin
                    r_pos_c <= step_c;
                    r_d     <= r_d - ar2;
                    r_pc    <= r_pc + dz2;
                end
                default: begin
                    r_pos_r <= step_r;
                    r_pos_c <= step_c;
                    r_d     <= r_d + ac2 - ar2;
                    r_pr    <= r_pr + dz2;
                    r_pc    <= r_pc + dz2;
                end
            endcase
        end
        if (i_cmd.latch_hs) begin
            r_hs <= r_rd_data;
        end
    end

endmodule

// ===== rtl/hmrs_ctrl.sv =====
// hmrs_ctrl: controller of the shadow test; input and output handshakes,
// result register, and the walk sequence over candidate cells.
// Depends on hmrs_pkg.
module hmrs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_mode,
    output logic               o_in_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_lit,
    output logic               o_was_query,
    output hmrs_pkg::t_dp_cmd  o_cmd,
    input  hmrs_pkg::t_dp_sts  i_sts
);
    import hmrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HS,
        S_CAND,
        S_TEST,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_cand  r_cand, n_cand;
    logic   r_first, n_first;
    logic   r_res, n_res;
    logic   r_out_valid, n_out_valid;
    logic   r_lit, n_lit;
    logic   r_wq, n_wq;

    logic   out_free;
    logic   accept;
    t_cand  cand;
    t_cand  cand_next;
    logic   cand_ok;
    logic   cand_last;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_lit       = r_lit;
    assign o_was_query = r_wq;

    always_comb begin
        if (r_first) begin
            cand = (i_sts.move == MOVE_COL) ? CAND_COL : CAND_ROW;
        end else begin
            cand = r_cand;
        end
        cand_next = (cand == CAND_ROW) ? CAND_COL : CAND_DIAG;
        cand_last = (i_sts.move != MOVE_CORNER) || (cand == CAND_DIAG);
        case (cand)
            CAND_ROW:  cand_ok = i_sts.row_ok;
            CAND_COL:  cand_ok = i_sts.col_ok;
            CAND_DIAG: cand_ok = i_sts.diag_ok;
            default:   cand_ok = i_sts.pos_ok;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_first     = r_first;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_lit       = r_lit;
        n_wq        = r_wq;

        o_cmd.load_write = 1'b0;
        o_cmd.start      = 1'b0;
        o_cmd.latch_hs   = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = CAND_CUR;
        o_cmd.advance    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_START;
                    end else begin
                        o_cmd.load_write = 1'b1;
                        n_out_valid      = 1'b1;
                        n_lit            = 1'b0;
                        n_wq             = 1'b0;
                    end
                end
            end
            S_START: begin
                if (i_sts.zero_dir || !i_sts.pos_ok) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = CAND_CUR;
                    n_state      = S_HS;
                end
            end
            S_HS: begin
                o_cmd.latch_hs = 1'b1;
                n_first        = 1'b1;
                n_state        = S_CAND;
            end
            S_CAND: begin
                if (r_first && !i_sts.pos_ok) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else if (cand_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cand;
                    n_cand       = cand;
                    n_first      = 1'b0;
                    n_state      = S_TEST;
                end else if (cand_last) begin
                    // candidate cell off the grid, nothing to read
                    o_cmd.advance = 1'b1;
                    n_first       = 1'b1;
                end else begin
                    n_cand  = cand_next;
                    n_first = 1'b0;
                end
            end
            S_TEST: begin
                if (i_sts.blocked) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else if (cand_last) begin
                    o_cmd.advance = 1'b1;
                    n_first       = 1'b1;
                    n_state       = S_CAND;
                end else begin
                    n_cand  = cand_next;
                    n_state = S_CAND;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_lit       = r_res;
                    n_wq        = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
        end
        r_cand <= n_cand;
        r_res  <= n_res;
        r_lit  <= n_lit;
        r_wq   <= n_wq;
    end

endmodule

// ===== rtl/heightmap_ray_shadow_test.sv =====
// heightmap_ray_shadow_test: shadow test of a cell against a height map.
// Instantiates hmrs_ctrl and hmrs_dp; depends on hmrs_pkg.
//
// Input channel (i_in_valid / o_in_stall): mode 0 loads one height cell,
// mode 1 asks whether the ray from a cell center toward the light is lit.
// Output channel (o_out_valid / i_out_stall): one item per input item, in
// order; loads are acknowledged with was_query 0 and lit 0.
// Config port (i_cfg_valid / o_cfg_ready, always ready): index 0 rows in use,
// index 1 columns in use; write only while the block is idle.
// A load shows its result in the cycle after it is taken. A query sets up,
// reads the start cell height, then walks the ray: each in-grid cell tested
// takes one height memory read (the single read port sets the pace), and each
// off-grid cell on the ray, the exit cell included, is stepped over with no
// read; a blocked query ends at the blocking cell, and a zero direction or a
// start off the grid answers without a walk. One item at a time.
// Reset clears control state and sets both grid sizes to 256; the height
// memory is not cleared and must be loaded before it is queried.
// While a result waits on a stalled receiver it holds and the input stalls.
module heightmap_ray_shadow_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [hmrs_pkg::RC_IN_W-1:0]        i_row,
    input  logic [hmrs_pkg::RC_IN_W-1:0]        i_col,
    input  logic [hmrs_pkg::HEIGHT_IN_W-1:0]    i_height,
    input  logic signed [hmrs_pkg::DIR_W-1:0]   i_dir_row,
    input  logic signed [hmrs_pkg::DIR_W-1:0]   i_dir_col,
    input  logic signed [hmrs_pkg::DIR_W-1:0]   i_dir_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_lit,
    output logic                                o_was_query,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hmrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hmrs_pkg::CFG_W-1:0]          i_cfg_data
);
    import hmrs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    hmrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_lit       (o_lit),
        .o_was_query (o_was_query),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    hmrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_height    (i_height),
        .i_dir_row   (i_dir_row),
        .i_dir_col   (i_dir_col),
        .i_dir_z     (i_dir_z),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== tb/sv/tb_heightmap_ray_shadow_test.sv =====
// tb_heightmap_ray_shadow_test: self-checking bench for the height map shadow test.
// Builds load and query items, predicts each lit/was_query answer in-bench, and
// checks every result in order; depends on hmrs_pkg and heightmap_ray_shadow_test.
module tb_heightmap_ray_shadow_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hmrs_pkg::*;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam int   FILL_CAP    = 30;
    localparam int   NUM_PHASES  = 9;
    localparam int   CYCLE_LIMIT = 20000000;

    typedef struct {
        logic                    mode;
        logic [RC_IN_W-1:0]      row;
        logic [RC_IN_W-1:0]      col;
        logic [HEIGHT_IN_W-1:0]  height;
        logic signed [DIR_W-1:0] dir_row;
        logic signed [DIR_W-1:0] dir_col;
        logic signed [DIR_W-1:0] dir_z;
        bit                      hold;
    } t_terrain_op;

    typedef struct {
        logic lit;
        logic was_query;
    } t_shade_answer;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_mode = 1'b0;
    logic [RC_IN_W-1:0]      i_row = '0;
    logic [RC_IN_W-1:0]      i_col = '0;
    logic [HEIGHT_IN_W-1:0]  i_height = '0;
    logic signed [DIR_W-1:0] i_dir_row = '0;
    logic signed [DIR_W-1:0] i_dir_col = '0;
    logic signed [DIR_W-1:0] i_dir_z = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_lit;
    logic                    o_was_query;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    // predictor state
    logic [HEIGHT_BITS-1:0]  height_mem [MEM_DEPTH];
    logic [CFG_W-1:0]        rows_reg = 9'd256;
    logic [CFG_W-1:0]        cols_reg = 9'd256;

    // stimulus side
    t_terrain_op             terrain_ops [$];
    t_shade_answer           shade_answers [$];
    t_terrain_op             cur_op = '{default: '0};
    bit                      sending = 1'b0;
    bit                      cell_loaded [MEM_DEPTH];
    bit                      hold_next = 1'b0;
    int                      op_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      fail_count = 0;
    int                      cycle_count = 0;

    int ph_rows  [NUM_PHASES] = '{5, 1, 12, 0, 2, 511, 3, 7, 256};
    int ph_cols  [NUM_PHASES] = '{7, 1, 12, 9, 300, 300, 40, 0, 256};
    int ph_items [NUM_PHASES] = '{150, 40, 200, 30, 120, 90, 160, 60, 180};
    int ph_send  [NUM_PHASES] = '{0, 48, 0, 24, 48, 0, 24, 0, 48};
    int ph_stall [NUM_PHASES] = '{0, 0, 48, 24, 0, 48, 24, 0, 0};

    heightmap_ray_shadow_test u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_height    (i_height),
        .i_dir_row   (i_dir_row),
        .i_dir_col   (i_dir_col),
        .i_dir_z     (i_dir_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_lit       (o_lit),
        .o_was_query (o_was_query),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int grid_span(input int cfg, input int cap);
        return (cfg > cap) ? cap : cfg;
    endfunction

    function automatic bit on_grid(input longint r, c, nr, nc);
        return r >= 0 && r < nr && c >= 0 && c < nc;
    endfunction

    function automatic int cell_addr(input longint r, c);
        return int'(r * MAX_COLS + c);
    endfunction

    function automatic bit cell_blocks(input longint r, c, nr, nc, hs, num, den, dz,
                                       ref int cells[$]);
        longint hc;
        if (!on_grid(r, c, nr, nc)) return 1'b0;
        cells = {cells, cell_addr(r, c)};
        hc = longint'(height_mem[cell_addr(r, c)]);
        return hc * den >= hs * den + num * dz;
    endfunction

    // walks every cell the planar ray crosses; collects the cells that get read
    function automatic bit trace_ray(input int r0, c0, dr, dc, dz, nr, nc,
                                     ref int cells[$]);
        longint r, c, ar, ac, sr, sc, kr, kc, hs, lr, lc, cmp;
        bit     clear;
        r = r0;
        c = c0;
        ar = (dr < 0) ? -dr : dr;
        ac = (dc < 0) ? -dc : dc;
        sr = (dr < 0) ? -1 : 1;
        sc = (dc < 0) ? -1 : 1;
        kr = 1;
        kc = 1;
        clear = 1'b1;
        if (!on_grid(r, c, nr, nc)) return 1'b1;
        cells = {cells, cell_addr(r, c)};
        if (ar == 0 && ac == 0) return 1'b1;
        hs = longint'(height_mem[cell_addr(r, c)]);
        while (on_grid(r, c, nr, nc)) begin
            lr = 2 * kr - 1;
            lc = 2 * kc - 1;
            if (ac == 0) cmp = -1;
            else if (ar == 0) cmp = 1;
            else cmp = lr * ac - lc * ar;
            if (cmp < 0) begin
                r += sr;
                if (cell_blocks(r, c, nr, nc, hs, lr, 2 * ar, dz, cells)) clear = 1'b0;
                kr++;
            end else if (cmp > 0) begin
                c += sc;
                if (cell_blocks(r, c, nr, nc, hs, lc, 2 * ac, dz, cells)) clear = 1'b0;
                kc++;
            end else begin
                if (cell_blocks(r + sr, c, nr, nc, hs, lr, 2 * ar, dz, cells)) clear = 1'b0;
                if (cell_blocks(r, c + sc, nr, nc, hs, lr, 2 * ar, dz, cells)) clear = 1'b0;
                r += sr;
                c += sc;
                if (cell_blocks(r, c, nr, nc, hs, lr, 2 * ar, dz, cells)) clear = 1'b0;
                kr++;
                kc++;
            end
        end
        return clear;
    endfunction

    function automatic t_shade_answer predict_shade(input t_terrain_op op);
        t_shade_answer ans;
        int            scratch[$];
        if (op.mode == MODE_LOAD) begin
            if (op.row < MAX_ROWS && op.col < MAX_COLS)
                height_mem[cell_addr(op.row, op.col)] = op.height;
            ans.lit = 1'b0;
            ans.was_query = 1'b0;
        end else begin
            ans.lit = trace_ray(int'(op.row), int'(op.col), int'(op.dir_row),
                                int'(op.dir_col), int'(op.dir_z),
                                grid_span(int'(rows_reg), MAX_ROWS),
                                grid_span(int'(cols_reg), MAX_COLS), scratch);
            ans.was_query = 1'b1;
        end
        return ans;
    endfunction

    function automatic int rand_dir(input int mag);
        return $urandom_range(2 * mag) - mag;
    endfunction

    function automatic int rand_sign();
        return $urandom_range(1) ? 1 : -1;
    endfunction

    function automatic int pick_height();
        int p;
        p = $urandom_range(99);
        if (p < 70) return $urandom_range(63);
        if (p < 85) return $urandom_range(65535);
        if (p < 95) return 0;
        return 65535;
    endfunction

    task automatic push_op(input t_terrain_op op);
        op.hold = hold_next;
        hold_next = 1'b0;
        terrain_ops = {terrain_ops, op};
        op_count++;
    endtask

    task automatic add_load(input int r, c, h);
        t_terrain_op op;
        op = '{default: '0};
        op.mode = MODE_LOAD;
        op.row = RC_IN_W'(r);
        op.col = RC_IN_W'(c);
        op.height = HEIGHT_IN_W'(h);
        cell_loaded[cell_addr(r, c)] = 1'b1;
        push_op(op);
    endtask

    // loads every cell the query may read that holds nothing yet, then the query
    task automatic add_query(input int r, c, dr, dc, dz, nr, nc);
        int          cells[$];
        t_terrain_op op;
        void'(trace_ray(r, c, dr, dc, dz, nr, nc, cells));
        foreach (cells[i])
            if (!cell_loaded[cells[i]])
                add_load(cells[i] / MAX_COLS, cells[i] % MAX_COLS, pick_height());
        op = '{default: '0};
        op.mode = MODE_QUERY;
        op.row = RC_IN_W'(r);
        op.col = RC_IN_W'(c);
        op.dir_row = DIR_W'(dr);
        op.dir_col = DIR_W'(dc);
        op.dir_z = DIR_W'(dz);
        push_op(op);
    endtask

    task automatic add_random_query(input int nr, nc);
        int r, c, dr, dc, dz, p, m, tries, fresh;
        int cells[$];
        fresh = 0;
        for (tries = 0; tries < 20; tries++) begin
            if (nr > 0 && nc > 0 && $urandom_range(99) < 85) begin
                r = $urandom_range(nr - 1);
                c = $urandom_range(nc - 1);
            end else begin
                r = $urandom_range(255);
                c = $urandom_range(255);
            end
            p = $urandom_range(99);
            if (p < 8) begin
                dr = 0;
                dc = 0;
            end else if (p < 26) begin
                if ($urandom_range(1)) begin
                    dr = rand_dir(6);
                    dc = 0;
                end else begin
                    dr = 0;
                    dc = rand_dir(6);
                end
            end else if (p < 46) begin
                m = $urandom_range(1, 4);
                dr = m * rand_sign();
                dc = ($urandom_range(1) ? m : 3 * m) * rand_sign();
                if ($urandom_range(1)) begin
                    m = dr;
                    dr = dc;
                    dc = m;
                end
            end else if (p < 80) begin
                dr = rand_dir(6);
                dc = rand_dir(6);
            end else begin
                dr = rand_dir(1023);
                dc = rand_dir(1023);
            end
            p = $urandom_range(99);
            if (p < 45) dz = rand_dir(8);
            else if (p < 90) dz = rand_dir(1023);
            else dz = (p < 94) ? -1023 : (p < 97) ? 1023 : 0;
            cells.delete();
            void'(trace_ray(r, c, dr, dc, dz, nr, nc, cells));
            fresh = 0;
            foreach (cells[i])
                if (!cell_loaded[cells[i]]) fresh++;
            if (fresh <= FILL_CAP) break;
        end
        if (fresh > FILL_CAP) begin
            dr = 0;
            dc = 0;
        end
        add_query(r, c, dr, dc, dz, nr, nc);
    endtask

    task automatic wait_idle();
        while (terrain_ops.size() != 0 || sending || shade_answers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sending && !o_in_stall) begin
                shade_answers = {shade_answers, predict_shade(cur_op)};
                sending = 1'b0;
            end
            if (!sending && terrain_ops.size() != 0 && $urandom_range(99) >= send_idle_pct
                && !(terrain_ops[0].hold && shade_answers.size() != 0)) begin
                cur_op = terrain_ops.pop_front();
                sending = 1'b1;
            end
        end
        i_in_valid <= sending;
        i_mode <= cur_op.mode;
        i_row <= cur_op.row;
        i_col <= cur_op.col;
        i_height <= cur_op.height;
        i_dir_row <= cur_op.dir_row;
        i_dir_col <= cur_op.dir_col;
        i_dir_z <= cur_op.dir_z;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_shade_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (shade_answers.size() == 0) begin
                $error("result with no item pending: lit %0b was_query %0b",
                       o_lit, o_was_query);
                fail_count++;
            end else begin
                want = shade_answers.pop_front();
                if (o_lit !== want.lit) begin
                    $error("lit mismatch: expected %0b, actual %0b", want.lit, o_lit);
                    fail_count++;
                end
                if (o_was_query !== want.was_query) begin
                    $error("was_query mismatch: expected %0b, actual %0b",
                           want.was_query, o_was_query);
                    fail_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ROWS) rows_reg <= i_cfg_data;
            else if (i_cfg_index == CFG_COLS) cols_reg <= i_cfg_data;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int nr, nc, mid, stop;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: height extremes, zero direction, edge exits, corner ties
        add_load(0, 0, 0);
        add_load(255, 255, 65535);
        add_query(0, 0, 0, 0, 1023, MAX_ROWS, MAX_COLS);
        add_query(255, 255, 1, 1, -1023, MAX_ROWS, MAX_COLS);
        add_query(254, 254, 1, 1, -1023, MAX_ROWS, MAX_COLS);
        add_query(0, 0, -1023, 1023, 1023, MAX_ROWS, MAX_COLS);
        add_query(0, 0, 0, -5, 0, MAX_ROWS, MAX_COLS);
        add_query(255, 0, 3, -1, -1023, MAX_ROWS, MAX_COLS);
        add_query(0, 254, -1, 2, -1, MAX_ROWS, MAX_COLS);
        add_query(255, 128, 1023, 0, 5, MAX_ROWS, MAX_COLS);
        add_query(128, 255, -1, 1023, -7, MAX_ROWS, MAX_COLS);
        add_query(1, 1, -2, -2, 0, MAX_ROWS, MAX_COLS);
        add_query(1, 1, -2, -2, 1023, MAX_ROWS, MAX_COLS);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = ph_send[p];
            recv_stall_pct = ph_stall[p];
            write_reg(CFG_ROWS, ph_rows[p]);
            write_reg(CFG_COLS, ph_cols[p]);
            repeat (2) @(posedge i_clk);
            nr = grid_span(ph_rows[p], MAX_ROWS);
            nc = grid_span(ph_cols[p], MAX_COLS);
            mid = op_count + ph_items[p] / 2;
            stop = op_count + ph_items[p];
            while (op_count < stop) begin
                if (op_count >= mid) begin
                    hold_next = 1'b1;
                    mid = stop;
                end
                if ($urandom_range(99) < 15)
                    add_load($urandom_range(255), $urandom_range(255), $urandom_range(65535));
                else
                    add_random_query(nr, nc);
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
